// ----- rtl/core/span_sprite_blitter_unit_macros.svh -----
// ---------------------------------------------------------------------------
// span_sprite_blitter_unit_macros
// Assertion macros for the span sprite blitter; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef SPAN_SPRITE_BLITTER_UNIT_MACROS_SVH
`define SPAN_SPRITE_BLITTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while rst is high
`define SSB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("span sprite blitter check failed");

// Next-cycle implication, sampled on clk, off while rst is high
`define SSB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("span sprite blitter check failed");

`else

`define SSB_ASSERT_IMP(label, ante, cons)
`define SSB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/core/ssb_pkg.sv -----
// ---------------------------------------------------------------------------
// ssb_pkg
// Shared widths, constants and types of the span sprite blitter.
// ---------------------------------------------------------------------------
`default_nettype none

package ssb_pkg;

  // Screen geometry, fixed by the result field widths
  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int COL_W         = $clog2(SCREEN_WIDTH);
  localparam int ROW_W         = $clog2(SCREEN_HEIGHT);

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 16;
  localparam int ADDR_W    = 19;
  localparam int LEN_W     = 10;
  localparam int POS_X_W   = 10;
  localparam int POS_Y_W   = 9;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_POS_X       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POS_Y       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_LEFT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_RIGHT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_TOP    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_BOTTOM = 3'd5;

  localparam logic [POS_X_W-1:0] CLIP_RIGHT_RESET  = 10'd639;
  localparam logic [POS_Y_W-1:0] CLIP_BOTTOM_RESET = 9'd479;

  // Parameter defaults
  localparam int HEADER_BYTES_DEF   = 16;
  localparam int MAX_SPRITE_DIM_DEF = 1023;

  // Result queue
  localparam int QUEUE_DEPTH = 6;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
    logic [POS_X_W-1:0] clip_left;
    logic [POS_X_W-1:0] clip_right;
    logic [POS_Y_W-1:0] clip_top;
    logic [POS_Y_W-1:0] clip_bottom;
  } clip_cfg_t;

  // One run of sprite columns [col_a, col_b) with one value
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] col_a;
    logic [WORD_W-1:0] col_b;
    logic [BYTE_W-1:0] pixel;
  } run_req_t;

  // Work handed from the parser to the clipper for one byte
  typedef struct packed {
    logic              valid;
    logic              image_end;
    logic [WORD_W-1:0] row;
    run_req_t          run0;
    run_req_t          run1;
  } blit_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [LEN_W-1:0]  run_length;
    logic [BYTE_W-1:0] pixel_value;
    logic              image_done;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

`default_nettype wire

// ----- rtl/core/ssb_parser.sv -----
// ---------------------------------------------------------------------------
// ssb_parser
// Byte parser of the sprite stream; registers the runs each byte causes.
// ---------------------------------------------------------------------------
`default_nettype none

module ssb_parser #(
  parameter int HEADER_BYTES   = ssb_pkg::HEADER_BYTES_DEF,
  parameter int MAX_SPRITE_DIM = ssb_pkg::MAX_SPRITE_DIM_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire logic [ssb_pkg::BYTE_W-1:0] image_byte,
  output ssb_pkg::blit_req_t             req
);

  import ssb_pkg::*;

  localparam int DIM_W = $clog2(MAX_SPRITE_DIM + 1);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_ROWHDR = 2'd1;
  localparam logic [1:0] PH_SPAN   = 2'd2;

  // Header byte offsets
  localparam logic [WORD_W-1:0] HDR_WIDTH_LO  = 16'd2;
  localparam logic [WORD_W-1:0] HDR_WIDTH_HI  = 16'd3;
  localparam logic [WORD_W-1:0] HDR_HEIGHT_LO = 16'd4;
  localparam logic [WORD_W-1:0] HDR_HEIGHT_HI = 16'd5;
  // Row header byte offsets
  localparam logic [WORD_W-1:0] ROW_START_LO  = 16'd0;
  localparam logic [WORD_W-1:0] ROW_START_HI  = 16'd1;
  localparam logic [WORD_W-1:0] ROW_LENGTH_LO = 16'd2;

  logic [1:0]        parse_phase,   parse_phase_next;
  logic [WORD_W-1:0] byte_counter,  byte_counter_next;
  logic [DIM_W-1:0]  sprite_width,  sprite_width_next;
  logic [DIM_W-1:0]  sprite_height, sprite_height_next;
  logic [DIM_W-1:0]  row_index,     row_index_next;
  logic [WORD_W-1:0] span_start,    span_start_next;
  logic [WORD_W-1:0] span_length,   span_length_next;
  logic [BYTE_W-1:0] low_byte_hold, low_byte_hold_next;
  blit_req_t         req_next;

  logic [WORD_W-1:0] byte_word;
  logic [DIM_W-1:0]  row_inc;
  logic [WORD_W:0]   span_x;
  logic [WORD_W:0]   span_end;
  logic [WORD_W:0]   count_inc;
  logic [WORD_W:0]   width_ext;

  // Clamp a header dimension to the largest sprite size
  function automatic logic [DIM_W-1:0] sat_dim(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] lim;
    lim = WORD_W'(MAX_SPRITE_DIM);
    return (v > lim) ? DIM_W'(lim) : DIM_W'(v);
  endfunction

  assign byte_word = {image_byte, low_byte_hold};
  assign row_inc   = row_index + DIM_W'(1);
  assign span_x    = {1'b0, span_start} + {1'b0, byte_counter};
  assign span_end  = {1'b0, span_start} + {1'b0, span_length};
  assign count_inc = {1'b0, byte_counter} + 17'd1;
  assign width_ext = (WORD_W + 1)'(sprite_width);

  // Decode one byte: update parser state and collect the runs it causes
  always_comb begin
    parse_phase_next   = parse_phase;
    byte_counter_next  = byte_counter;
    sprite_width_next  = sprite_width;
    sprite_height_next = sprite_height;
    row_index_next     = row_index;
    span_start_next    = span_start;
    span_length_next   = span_length;
    low_byte_hold_next = low_byte_hold;
    req_next           = '0;
    req_next.valid     = 1'b1;
    req_next.row       = WORD_W'(row_index);

    case (parse_phase)
      PH_HEADER: begin
        if (byte_counter == HDR_WIDTH_LO || byte_counter == HDR_HEIGHT_LO) begin
          low_byte_hold_next = image_byte;
        end else if (byte_counter == HDR_WIDTH_HI) begin
          sprite_width_next = sat_dim(byte_word);
        end else if (byte_counter == HDR_HEIGHT_HI) begin
          sprite_height_next = sat_dim(byte_word);
        end
        byte_counter_next = count_inc[WORD_W-1:0];
        if (count_inc >= (WORD_W + 1)'(HEADER_BYTES)) begin
          byte_counter_next = '0;
          row_index_next    = '0;
          if (sprite_height_next == '0) begin
            req_next.image_end = 1'b1;
            parse_phase_next   = PH_HEADER;
          end else begin
            parse_phase_next = PH_ROWHDR;
          end
        end
      end

      PH_ROWHDR: begin
        if (byte_counter == ROW_START_LO || byte_counter == ROW_LENGTH_LO) begin
          low_byte_hold_next = image_byte;
          byte_counter_next  = count_inc[WORD_W-1:0];
        end else if (byte_counter == ROW_START_HI) begin
          span_start_next   = byte_word;
          byte_counter_next = ROW_LENGTH_LO;
        end else begin
          span_length_next  = byte_word;
          byte_counter_next = '0;
          req_next.run0.valid = 1'b1;
          req_next.run0.col_a = '0;
          req_next.run0.pixel = '0;
          if (byte_word == '0) begin
            // Empty span: whole row as one zero run, then close the row
            req_next.run0.col_b = WORD_W'(sprite_width);
            if (row_inc >= sprite_height) begin
              req_next.image_end = 1'b1;
              parse_phase_next   = PH_HEADER;
              row_index_next     = '0;
            end else begin
              row_index_next   = row_inc;
              parse_phase_next = PH_ROWHDR;
            end
          end else begin
            // Leading zero run up to the span start
            req_next.run0.col_b = (span_start < WORD_W'(sprite_width)) ?
                                  span_start : WORD_W'(sprite_width);
            parse_phase_next = PH_SPAN;
          end
        end
      end

      PH_SPAN: begin
        if (span_x < width_ext) begin
          req_next.run0.valid = 1'b1;
          req_next.run0.col_a = span_x[WORD_W-1:0];
          req_next.run0.col_b = span_x[WORD_W-1:0] + WORD_W'(1);
          req_next.run0.pixel = image_byte;
        end
        byte_counter_next = count_inc[WORD_W-1:0];
        if (count_inc >= {1'b0, span_length}) begin
          // Trailing zero run after the span, then close the row
          if (span_end < width_ext) begin
            req_next.run1.valid = 1'b1;
            req_next.run1.col_a = span_end[WORD_W-1:0];
            req_next.run1.col_b = WORD_W'(sprite_width);
            req_next.run1.pixel = '0;
          end
          byte_counter_next = '0;
          if (row_inc >= sprite_height) begin
            req_next.image_end = 1'b1;
            parse_phase_next   = PH_HEADER;
            row_index_next     = '0;
          end else begin
            row_index_next   = row_inc;
            parse_phase_next = PH_ROWHDR;
          end
        end
      end

      default: begin
        // Unused phase code: drop back to the header
        parse_phase_next  = PH_HEADER;
        byte_counter_next = '0;
      end
    endcase
  end

  // Advance parser state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_HEADER;
      byte_counter  <= '0;
      sprite_width  <= '0;
      sprite_height <= '0;
      row_index     <= '0;
      span_start    <= '0;
      span_length   <= '0;
      low_byte_hold <= '0;
    end else if (accept) begin
      parse_phase   <= parse_phase_next;
      byte_counter  <= byte_counter_next;
      sprite_width  <= sprite_width_next;
      sprite_height <= sprite_height_next;
      row_index     <= row_index_next;
      span_start    <= span_start_next;
      span_length   <= span_length_next;
      low_byte_hold <= low_byte_hold_next;
    end
  end

  // Hold the runs of the last transfer for the clipper
  always_ff @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      req.valid <= accept;
    end
    if (accept) begin
      req.image_end <= req_next.image_end;
      req.row       <= req_next.row;
      req.run0      <= req_next.run0;
      req.run1      <= req_next.run1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ssb_clip.sv -----
// ---------------------------------------------------------------------------
// ssb_clip
// Clips registered runs to the screen rectangle and forms the results.
// ---------------------------------------------------------------------------
`default_nettype none

module ssb_clip (
  input  wire ssb_pkg::blit_req_t req,
  input  wire ssb_pkg::clip_cfg_t cfg,
  output ssb_pkg::push_t          push
);

  import ssb_pkg::*;

  typedef struct packed {
    logic    keep;
    result_t res;
  } clip_out_t;

  logic [WORD_W:0] ry;
  logic            row_ok;
  logic [COL_W:0]  col_limit;
  clip_out_t       out0;
  clip_out_t       out1;

  // Clip one run to the column window and form its address
  function automatic clip_out_t clip_run(input run_req_t r, input clip_cfg_t c,
                                         input logic [WORD_W:0] row,
                                         input logic row_in, input logic [COL_W:0] lim);
    logic [WORD_W:0] lo;
    logic [WORD_W:0] hi;
    clip_out_t       o;
    lo = (WORD_W + 1)'(c.pos_x) + {1'b0, r.col_a};
    hi = (WORD_W + 1)'(c.pos_x) + {1'b0, r.col_b};
    if (lo < (WORD_W + 1)'(c.clip_left)) lo = (WORD_W + 1)'(c.clip_left);
    if (hi > (WORD_W + 1)'(lim)) hi = (WORD_W + 1)'(lim);
    o.keep = r.valid && row_in && (r.col_a < r.col_b) && (lo < hi);
    o.res.write_address = ADDR_W'(row[ROW_W-1:0]) * ADDR_W'(SCREEN_WIDTH) +
                          ADDR_W'(lo[COL_W-1:0]);
    o.res.run_length    = LEN_W'(hi - lo);
    o.res.pixel_value   = r.pixel;
    o.res.image_done    = 1'b0;
    return o;
  endfunction

  assign ry     = (WORD_W + 1)'(cfg.pos_y) + {1'b0, req.row};
  assign row_ok = (ry >= (WORD_W + 1)'(cfg.clip_top)) &&
                  (ry <= (WORD_W + 1)'(cfg.clip_bottom)) &&
                  (ry <  (WORD_W + 1)'(SCREEN_HEIGHT));

  // Right edge: the tighter of clip_right + 1 and the screen width
  always_comb begin
    col_limit = (COL_W + 1)'(cfg.clip_right) + (COL_W + 1)'(1);
    if (col_limit > (COL_W + 1)'(SCREEN_WIDTH)) col_limit = (COL_W + 1)'(SCREEN_WIDTH);
  end

  assign out0 = clip_run(req.run0, cfg, ry, row_ok, col_limit);
  assign out1 = clip_run(req.run1, cfg, ry, row_ok, col_limit);

  // Pack kept runs in order; mark the last one of the image, or emit an empty end
  always_comb begin
    push = '0;
    if (req.valid) begin
      if (out0.keep && out1.keep) begin
        push.count = 2'd2;
        push.res0  = out0.res;
        push.res1  = out1.res;
        push.res1.image_done = req.image_end;
      end else if (out0.keep || out1.keep) begin
        push.count = 2'd1;
        push.res0  = out0.keep ? out0.res : out1.res;
        push.res0.image_done = req.image_end;
      end else if (req.image_end) begin
        push.count = 2'd1;
        push.res0.image_done = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/span_sprite_blitter_unit.sv -----
// ---------------------------------------------------------------------------
// span_sprite_blitter_unit
// Span-encoded sprite blitter: parses a byte stream into clipped framebuffer
// write runs.
// ---------------------------------------------------------------------------
// The parser registers the runs of a byte at its transfer; the clipper forms
// their results combinationally and the queue registers them for output.
// Throughput: one byte per cycle while the queue has room for two results
// beyond those in flight; one result leaves per cycle while out_ready is high.
// Reset: synchronous rst clears the parser, empties the queue and loads the
// register reset values; no clearing pass.
`default_nettype none

`include "span_sprite_blitter_unit_macros.svh"

module span_sprite_blitter_unit #(
  parameter int HEADER_BYTES   = ssb_pkg::HEADER_BYTES_DEF,
  parameter int MAX_SPRITE_DIM = ssb_pkg::MAX_SPRITE_DIM_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ssb_pkg::BYTE_W-1:0]     image_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ssb_pkg::ADDR_W-1:0]          write_address,
  output logic [ssb_pkg::LEN_W-1:0]           run_length,
  output logic [ssb_pkg::BYTE_W-1:0]          pixel_value,
  output logic                                image_done,
  input  wire logic                           cfg_write,
  input  wire logic [ssb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ssb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import ssb_pkg::*;

  clip_cfg_t        cfg;
  blit_req_t        req;
  push_t            push;
  logic             in_accept;
  logic             pop;

  result_t          entries      [QUEUE_DEPTH];
  result_t          entries_next [QUEUE_DEPTH];
  result_t          shifted      [QUEUE_DEPTH];
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] base;
  logic [CNT_W:0]   reserve;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pos_x       <= '0;
      cfg.pos_y       <= '0;
      cfg.clip_left   <= '0;
      cfg.clip_right  <= CLIP_RIGHT_RESET;
      cfg.clip_top    <= '0;
      cfg.clip_bottom <= CLIP_BOTTOM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POS_X:       cfg.pos_x       <= cfg_data[POS_X_W-1:0];
        REG_POS_Y:       cfg.pos_y       <= cfg_data[POS_Y_W-1:0];
        REG_CLIP_LEFT:   cfg.clip_left   <= cfg_data[POS_X_W-1:0];
        REG_CLIP_RIGHT:  cfg.clip_right  <= cfg_data[POS_X_W-1:0];
        REG_CLIP_TOP:    cfg.clip_top    <= cfg_data[POS_Y_W-1:0];
        REG_CLIP_BOTTOM: cfg.clip_bottom <= cfg_data[POS_Y_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Take a byte only when the queue has room for everything in flight
  assign reserve   = (CNT_W + 1)'(count) + (req.valid ? (CNT_W + 1)'(2) : '0) +
                     (CNT_W + 1)'(2);
  assign in_ready  = (reserve <= (CNT_W + 1)'(QUEUE_DEPTH));
  assign in_accept = in_valid && in_ready;

  ssb_parser #(
    .HEADER_BYTES   (HEADER_BYTES),
    .MAX_SPRITE_DIM (MAX_SPRITE_DIM)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .image_byte (image_byte),
    .req        (req)
  );

  ssb_clip u_clip (
    .req  (req),
    .cfg  (cfg),
    .push (push)
  );

  // Result queue: head at entry zero, shift on each output transfer
  assign pop  = out_valid && out_ready;
  assign base = count - CNT_W'(pop);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      shifted[i] = entries[i + 1];
    end
    shifted[QUEUE_DEPTH-1] = entries[QUEUE_DEPTH-1];
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      entries_next[i] = pop ? shifted[i] : entries[i];
      if (push.count != 2'd0 && CNT_W'(i) == base) begin
        entries_next[i] = push.res0;
      end
      if (push.count == 2'd2 && CNT_W'(i) == base + CNT_W'(1)) begin
        entries_next[i] = push.res1;
      end
    end
    count_next = base + CNT_W'(push.count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      entries[i] <= entries_next[i];
    end
  end

  assign out_valid     = (count != '0);
  assign write_address = entries[0].write_address;
  assign run_length    = entries[0].run_length;
  assign pixel_value   = entries[0].pixel_value;
  assign image_done    = entries[0].image_done;

  // Checks
  `SSB_ASSERT_IMP(a_queue_bound, 1'b1, count <= CNT_W'(QUEUE_DEPTH))
  `SSB_ASSERT_NEXT(a_transfer_to_req, in_accept, req.valid)
  `SSB_ASSERT_IMP(a_end_gives_result, req.valid && req.image_end, push.count != 2'd0)
  `SSB_ASSERT_IMP(a_empty_is_final, out_valid && run_length == '0, image_done && write_address == '0 && pixel_value == '0)

endmodule

`default_nettype wire

// ----- tb/blit_run_checker.sv -----
// ---------------------------------------------------------------------------
// blit_run_checker
// Watches the byte, run and register ports of the span sprite blitter, keeps
// its own copy of the sprite parser and clip settings, and compares every
// run transfer against the oldest predicted framebuffer write.
// ---------------------------------------------------------------------------
module blit_run_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire logic                            in_ready,
  input  wire logic [ssb_pkg::BYTE_W-1:0]      image_byte,
  input  wire logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire logic [ssb_pkg::ADDR_W-1:0]      write_address,
  input  wire logic [ssb_pkg::LEN_W-1:0]       run_length,
  input  wire logic [ssb_pkg::BYTE_W-1:0]      pixel_value,
  input  wire logic                            image_done,
  input  wire logic                            cfg_write,
  input  wire logic [ssb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ssb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                   mismatches,
  output int                                   pending_runs
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssb_pkg::*;

  localparam int MAX_REPORTS = 20;
  localparam int DIM_W       = 10;

  typedef enum logic [1:0] {PHASE_HEADER, PHASE_ROW_HEAD, PHASE_SPAN} parse_phase_e;

  // Register copy
  logic [POS_X_W-1:0] pos_x, clip_left, clip_right;
  logic [POS_Y_W-1:0] pos_y, clip_top, clip_bottom;

  // Parser copy
  parse_phase_e       phase;
  logic [WORD_W-1:0]  byte_count, span_start, span_len;
  logic [DIM_W-1:0]   sprite_w, sprite_h, row;
  logic [BYTE_W-1:0]  low_hold;
  int                 byte_runs;

  result_t            expected_runs[$];

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [WORD_W-1:0] v);
    return (v > MAX_SPRITE_DIM_DEF) ? DIM_W'(MAX_SPRITE_DIM_DEF) : DIM_W'(v);
  endfunction

  // Queue one clipped run covering sprite columns [col_a, col_b) of this row
  function automatic void push_run(input int unsigned col_a, col_b,
                                   input logic [BYTE_W-1:0] pix);
    int unsigned scr_row, lo, hi, lim;
    result_t     r;
    scr_row = pos_y + row;
    if (col_a >= col_b) return;
    if (scr_row < clip_top || scr_row > clip_bottom || scr_row >= SCREEN_HEIGHT) return;
    lo = pos_x + col_a;
    hi = pos_x + col_b;
    if (lo < clip_left) lo = clip_left;
    lim = clip_right + 1;
    if (lim > SCREEN_WIDTH) lim = SCREEN_WIDTH;
    if (hi > lim) hi = lim;
    if (lo >= hi) return;
    r.write_address = ADDR_W'(scr_row * SCREEN_WIDTH + lo);
    r.run_length    = LEN_W'(hi - lo);
    r.pixel_value   = pix;
    r.image_done    = 1'b0;
    expected_runs.push_back(r);
    byte_runs++;
  endfunction

  // Flag the last run of the image, or queue the empty closing run
  function automatic void end_image();
    result_t r;
    if (byte_runs > 0) begin
      r = expected_runs.pop_back();
      r.image_done = 1'b1;
    end else begin
      r = '0;
      r.image_done = 1'b1;
    end
    expected_runs.push_back(r);
    phase      = PHASE_HEADER;
    byte_count = '0;
    row        = '0;
  endfunction

  function automatic void end_row();
    row        = row + 1'b1;
    byte_count = '0;
    if (row >= sprite_h) end_image();
    else phase = PHASE_ROW_HEAD;
  endfunction

  // Advance the parser by one byte and queue the runs it gives
  function automatic void take_byte(input logic [BYTE_W-1:0] b);
    int unsigned k, col, span_end;
    k         = byte_count;
    byte_runs = 0;
    case (phase)
      PHASE_HEADER: begin
        if (k == 2 || k == 4) low_hold = b;
        else if (k == 3) sprite_w = clamp_dim({b, low_hold});
        else if (k == 5) sprite_h = clamp_dim({b, low_hold});
        byte_count = WORD_W'(k + 1);
        if (k + 1 >= HEADER_BYTES_DEF) begin
          byte_count = '0;
          row        = '0;
          if (sprite_h == 0) end_image();
          else phase = PHASE_ROW_HEAD;
        end
      end
      PHASE_ROW_HEAD: begin
        if (k == 0 || k == 2) begin
          low_hold   = b;
          byte_count = WORD_W'(k + 1);
        end else if (k == 1) begin
          span_start = {b, low_hold};
          byte_count = WORD_W'(2);
        end else begin
          span_len   = {b, low_hold};
          byte_count = '0;
          if (span_len == 0) begin
            push_run(0, sprite_w, '0);
            end_row();
          end else begin
            push_run(0, (span_start < sprite_w) ? span_start : sprite_w, '0);
            phase = PHASE_SPAN;
          end
        end
      end
      PHASE_SPAN: begin
        col      = span_start + k;
        span_end = span_start + span_len;
        if (col < sprite_w) push_run(col, col + 1, b);
        k          = k + 1;
        byte_count = WORD_W'(k);
        if (k >= span_len) begin
          if (span_end < sprite_w) push_run(span_end, sprite_w, '0);
          end_row();
        end
      end
      default: begin
        phase      = PHASE_HEADER;
        byte_count = '0;
      end
    endcase
  endfunction

  function automatic logic field_differs(input string field_name,
                                         input logic [31:0] want, got);
    if (got === want) return 1'b0;
    if (mismatches < MAX_REPORTS)
      $display("%0t: %s expected %0d got %0d", $time, field_name, want, got);
    return 1'b1;
  endfunction

  // Sample at the falling edge: everything is settled for the next rising edge
  always @(negedge clk) begin
    result_t seen, want;
    logic    bad;
    if (rst) begin
      pos_x       = '0;
      pos_y       = '0;
      clip_left   = '0;
      clip_right  = CLIP_RIGHT_RESET;
      clip_top    = '0;
      clip_bottom = CLIP_BOTTOM_RESET;
      phase       = PHASE_HEADER;
      byte_count  = '0;
      sprite_w    = '0;
      sprite_h    = '0;
      row         = '0;
      span_start  = '0;
      span_len    = '0;
      low_hold    = '0;
      mismatches  = 0;
      expected_runs.delete();
    end else begin
      // Check a run transfer against the oldest prediction
      if (out_valid && out_ready) begin
        seen.write_address = write_address;
        seen.run_length    = run_length;
        seen.pixel_value   = pixel_value;
        seen.image_done    = image_done;
        if (expected_runs.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: expected no run, got addr %0d len %0d pix %0d done %0b",
                     $time, write_address, run_length, pixel_value, image_done);
          mismatches++;
        end else begin
          want = expected_runs.pop_front();
          bad  = field_differs("write_address", want.write_address, seen.write_address);
          bad |= field_differs("run_length", want.run_length, seen.run_length);
          bad |= field_differs("pixel_value", want.pixel_value, seen.pixel_value);
          bad |= field_differs("image_done", want.image_done, seen.image_done);
          if (bad) mismatches++;
        end
      end
      // Predict the runs of a byte transfer
      if (in_valid && in_ready) take_byte(image_byte);
      // Track register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_POS_X:       pos_x       = cfg_data;
          REG_POS_Y:       pos_y       = cfg_data[POS_Y_W-1:0];
          REG_CLIP_LEFT:   clip_left   = cfg_data;
          REG_CLIP_RIGHT:  clip_right  = cfg_data;
          REG_CLIP_TOP:    clip_top    = cfg_data[POS_Y_W-1:0];
          REG_CLIP_BOTTOM: clip_bottom = cfg_data[POS_Y_W-1:0];
          default: ;
        endcase
      end
    end
    pending_runs = expected_runs.size();
  end

endmodule

// ----- tb/tb_span_sprite_blitter_unit.sv -----
// ---------------------------------------------------------------------------
// tb_span_sprite_blitter_unit
// Feeds span-encoded sprite images through the blitter under several clip
// and position settings, with random idling and back-pressure on both
// channels; a checker beside the block predicts and compares every run.
// ---------------------------------------------------------------------------
module tb_span_sprite_blitter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ssb_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int HDR_W_LO      = 2;
  localparam int HDR_W_HI      = 3;
  localparam int HDR_H_LO      = 4;
  localparam int HDR_H_HI      = 5;
  localparam int MAX_COL       = SCREEN_WIDTH - 1;
  localparam int MAX_ROW       = SCREEN_HEIGHT - 1;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   in_valid   = 1'b0;
  logic                   in_ready;
  logic [BYTE_W-1:0]      image_byte = '0;
  logic                   out_valid;
  logic                   out_ready  = 1'b0;
  logic [ADDR_W-1:0]      write_address;
  logic [LEN_W-1:0]       run_length;
  logic [BYTE_W-1:0]      pixel_value;
  logic                   image_done;
  logic                   cfg_write  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  int send_idle_pct = 32;
  int recv_idle_pct = 83;
  int hold_kicks    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int bytes_sent    = 0;
  int cycle_count   = 0;
  int mismatches;
  int pending_runs;

  span_sprite_blitter_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .image_byte    (image_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_address (write_address),
    .run_length    (run_length),
    .pixel_value   (pixel_value),
    .image_done    (image_done),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  blit_run_checker u_run_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .image_byte    (image_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_address (write_address),
    .run_length    (run_length),
    .pixel_value   (pixel_value),
    .image_done    (image_done),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending_runs  (pending_runs)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Count down a long receiver hold-off once kicked
  always @(posedge clk) begin
    if (hold_kicks != hold_seen) begin
      hold_seen <= hold_kicks;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Drop ready at random, or for the whole hold-off
  always @(posedge clk) begin
    if (hold_left != 0) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_span_sprite_blitter_unit: errors");
      $finish;
    end
  end

  // Offer one byte, idling first at random, and hold it until the transfer
  task automatic send_byte(input logic [BYTE_W-1:0] value);
    logic taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    image_byte <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  task automatic send_word(input logic [WORD_W-1:0] w);
    send_byte(w[7:0]);
    send_byte(w[15:8]);
  endtask

  task automatic send_header(input logic [WORD_W-1:0] w, h);
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < HEADER_BYTES_DEF; i++) begin
      case (i)
        HDR_W_LO: b = w[7:0];
        HDR_W_HI: b = w[15:8];
        HDR_H_LO: b = h[7:0];
        HDR_H_HI: b = h[15:8];
        default:  b = BYTE_W'($urandom);
      endcase
      send_byte(b);
    end
  endtask

  // One row: span start, span length, then random span bytes
  task automatic send_span(input logic [WORD_W-1:0] start, len);
    send_word(start);
    send_word(len);
    for (int i = 0; i < len; i++) send_byte(BYTE_W'($urandom));
  endtask

  // Let every predicted run drain, then the block's own latency
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_runs != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input int unsigned px, py, cl, cr, ct, cb);
    int unsigned            values [6];
    logic [CFG_INDEX_W-1:0] reg_order [6];
    wait_idle();
    values    = '{px, py, cl, cr, ct, cb};
    reg_order = '{REG_POS_X, REG_POS_Y, REG_CLIP_LEFT,
                  REG_CLIP_RIGHT, REG_CLIP_TOP, REG_CLIP_BOTTOM};
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= reg_order[i];
      cfg_data  <= CFG_DATA_W'(values[i]);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // Full screen, an arbitrary (maybe inverted) rectangle, or one around the sprite position
  task automatic apply_random_setting();
    int unsigned px, py, cl, cr, ct, cb;
    int          kind;
    kind = $urandom_range(0, 5);
    px   = $urandom_range(0, MAX_COL);
    py   = $urandom_range(0, MAX_ROW);
    if (kind == 0) begin
      cl = 0;
      cr = MAX_COL;
      ct = 0;
      cb = MAX_ROW;
    end else if (kind == 1) begin
      cl = $urandom_range(0, MAX_COL);
      cr = $urandom_range(0, MAX_COL);
      ct = $urandom_range(0, MAX_ROW);
      cb = $urandom_range(0, MAX_ROW);
    end else begin
      cl = $urandom_range(0, px);
      cr = $urandom_range(px, MAX_COL);
      ct = $urandom_range(0, py);
      cb = $urandom_range(py, MAX_ROW);
    end
    apply_setting(px, py, cl, cr, ct, cb);
  endtask

  // Mostly narrow, short sprites; now and then a huge width, zero height,
  // an empty row or a span start far off the sprite
  task automatic send_random_image();
    logic [WORD_W-1:0] w, h, start, len;
    int                start_max, kind;
    kind      = $urandom_range(0, 9);
    w         = (kind == 0) ? WORD_W'($urandom) : WORD_W'($urandom_range(0, 48));
    h         = (kind == 1) ? '0 : WORD_W'($urandom_range(1, 5));
    start_max = (w > 60) ? 64 : int'(w) + 4;
    send_header(w, h);
    for (int r = 0; r < h; r++) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        start = WORD_W'($urandom);
        len   = '0;
      end else if (kind == 1) begin
        start = WORD_W'($urandom);
        len   = WORD_W'($urandom_range(1, 6));
      end else begin
        start = WORD_W'($urandom_range(0, start_max));
        len   = WORD_W'($urandom_range(1, 24));
      end
      send_span(start, len);
    end
  endtask

  task automatic run_random(input int count);
    int target;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 3) == 0) apply_random_setting();
      send_random_image();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: zero height gives only the empty closing run
    send_header(16'd5, 16'd0);
    // Zero runs around a span, an empty row, a span running past the width
    send_header(16'd8, 16'd3);
    send_word(16'd2);
    send_word(16'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_span(16'd0, 16'd0);
    send_span(16'd6, 16'd5);
    // Span start beyond the width
    send_header(16'd4, 16'd1);
    send_span(16'd10, 16'd2);
    // Zero width: nothing written at all
    send_header(16'd0, 16'd2);
    send_span(16'd0, 16'd0);
    send_span(16'd0, 16'd1);
    // Oversized width saturates; the zero runs stop at the screen edge
    send_header(16'h0401, 16'd2);
    repeat (2) send_span(16'd0, 16'd0);

    // Bottom-right corner position: off-screen clipping, last row clipped
    apply_setting(MAX_COL, MAX_ROW, 0, MAX_COL, 0, MAX_ROW);
    send_header(16'd3, 16'd2);
    send_span(16'd0, 16'd3);
    send_span(16'd1, 16'd1);
    // One-pixel window at the last framebuffer address
    apply_setting(630, 470, MAX_COL, MAX_COL, MAX_ROW, MAX_ROW);
    send_header(16'd16, 16'd12);
    repeat (12) send_span(16'd0, 16'd0);
    // One-pixel window at address zero
    apply_setting(0, 0, 0, 0, 0, 0);
    send_header(16'd4, 16'd2);
    send_span(16'd0, 16'd2);
    send_span(16'd0, 16'd0);
    // Inverted rectangle suppresses every write
    apply_setting(0, 0, 300, 100, 200, 50);
    send_header(16'd8, 16'd2);
    send_span(16'd1, 16'd4);
    send_span(16'd0, 16'd0);

    run_random(300);
    send_idle_pct = 83;
    recv_idle_pct <= 32;
    run_random(300);
    send_idle_pct = 0;
    recv_idle_pct <= 0;

    // Hold off the receiver while a wide image keeps arriving
    apply_setting(0, 0, 0, MAX_COL, 0, MAX_ROW);
    hold_kicks <= hold_kicks + 1;
    send_header(16'd48, 16'd6);
    repeat (6) send_span(16'd0, 16'd40);
    run_random(300);

    wait_idle();
    if (mismatches == 0 && pending_runs == 0) begin
      $display("tb_span_sprite_blitter_unit: clean");
    end else begin
      $display("tb_span_sprite_blitter_unit: errors");
    end
    $finish;
  end

endmodule
